// ----- sv/shabc_pkg.sv -----
// Shared types, constants and SHA-256 bit functions for the block compressor.
// No dependencies; every module imports this package.
package shabc_pkg;

  localparam int WORD_W      = 32;
  localparam int ROUNDS      = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int HASH_WORDS  = 8;
  localparam int ROUND_IDX_W = $clog2(ROUNDS);
  localparam int HASH_IDX_W  = $clog2(HASH_WORDS);

  typedef logic [WORD_W-1:0]      word_t;
  typedef logic [ROUND_IDX_W-1:0] round_idx_t;
  typedef logic [HASH_IDX_W-1:0]  hash_idx_t;

  // Controls from the sequencer to the round unit
  typedef struct packed {
    logic       load;   // copy chaining value into working variables
    logic       step;   // run one round
    round_idx_t idx;    // round number, selects K
  } round_ctrl_t;

  // Controls from the sequencer to the schedule window
  typedef struct packed {
    logic shift_in;     // push one message word
    logic step;         // expand one schedule word
  } sched_ctrl_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INITIAL_H [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- sv/shabc_in_if.sv -----
// Message word channel: valid/ready handshake with word and start flag.
// Standalone; no package dependency.
interface shabc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        start_message;

  modport source(output valid, output message_word, output start_message, input ready);
  modport sink(input valid, input message_word, input start_message, output ready);
endinterface

// ----- sv/shabc_out_if.sv -----
// Digest word channel: valid/ready handshake with word, index and last flag.
// Standalone; no package dependency.
interface shabc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface

// ----- sv/sha256_block_compress.sv -----
// SHA-256 block compression top: sequencer, chaining value, output port.
// Depends on shabc_pkg, shabc_in_if, shabc_out_if, shabc_sched, shabc_round.
//
//   channel | dir | payload                                | meaning
//   msg     | in  | message_word[31:0], start_message      | one block word per transaction
//   digest  | out | digest_word[31:0], word_index[2:0],    | eight chaining words per block,
//           |     | last_word                              | H0 first, last one flagged
//
// A block takes 16 word transactions, then 64 rounds, an add step and eight
// output transactions. The round count is set by the single round unit, which
// runs one round per cycle.
// msg.ready is high only while words are being collected; a stalled digest
// holds the block. Reset loads the initial hash constants and clears counts.
module sha256_block_compress (
  input  logic        clk,
  input  logic        rst,
  shabc_in_if.sink    msg,
  shabc_out_if.source digest
);
  import shabc_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [3:0]  word_count;
  logic [3:0]  word_count_next;
  round_idx_t  round_idx;
  hash_idx_t   out_idx;
  word_t       cv [HASH_WORDS];
  word_t       wv [HASH_WORDS];
  word_t       w_cur;
  logic        in_xfer;
  logic        out_xfer;
  logic        block_done;
  round_ctrl_t rctrl;
  sched_ctrl_t sctrl;

  assign in_xfer  = msg.valid && msg.ready;
  assign out_xfer = digest.valid && digest.ready;

  // Count block words; a start flag restarts the block at this word
  assign word_count_next = (msg.start_message ? 4'd0 : word_count) + 4'd1;
  assign block_done      = in_xfer && (word_count_next == 4'd0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:  if (block_done) state_next = S_ROUND;
      S_ROUND: if (round_idx == round_idx_t'(ROUNDS-1)) state_next = S_ADD;
      S_ADD:   state_next = S_EMIT;
      S_EMIT:  if (out_xfer && out_idx == hash_idx_t'(HASH_WORDS-1)) state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      word_count <= 4'd0;
      round_idx  <= '0;
      out_idx    <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) word_count <= word_count_next;
      if (state == S_ROUND) round_idx <= round_idx + round_idx_t'(1);
      else round_idx <= '0;
      if (state == S_EMIT) begin
        if (out_xfer) out_idx <= out_idx + hash_idx_t'(1);
      end else begin
        out_idx <= '0;
      end
    end
  end

  // Chaining value: reload on start, accumulate after the rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < HASH_WORDS; j++) cv[j] <= INITIAL_H[j];
    end else if (in_xfer && msg.start_message) begin
      for (int j = 0; j < HASH_WORDS; j++) cv[j] <= INITIAL_H[j];
    end else if (state == S_ADD) begin
      for (int j = 0; j < HASH_WORDS; j++) cv[j] <= cv[j] + wv[j];
    end
  end

  // Datapath controls
  always_comb begin
    sctrl.shift_in = in_xfer;
    sctrl.step     = (state == S_ROUND);
    rctrl.load     = block_done;
    rctrl.step     = (state == S_ROUND);
    rctrl.idx      = round_idx;
  end

  shabc_sched u_sched (
    .clk     (clk),
    .ctrl    (sctrl),
    .word_in (msg.message_word),
    .w_cur   (w_cur)
  );

  shabc_round u_round (
    .clk  (clk),
    .ctrl (rctrl),
    .cv   (cv),
    .w    (w_cur),
    .wv   (wv)
  );

  // Ports
  assign msg.ready          = (state == S_LOAD);
  assign digest.valid       = (state == S_EMIT);
  assign digest.digest_word = cv[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == hash_idx_t'(HASH_WORDS-1));

  // Checks
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("input accepted while digest is pending");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round_idx == round_idx_t'(ROUNDS-1)) |=> (state == S_ADD))
    else $error("round sequence did not end after the last round");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && digest.last_word) |=> (state == S_LOAD && out_idx == '0))
    else $error("sequencer did not return to load after last digest word");

  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (word_count == 4'd0))
    else $error("word count not clear while compressing");

endmodule

// ----- sv/shabc_sched.sv -----
// Message schedule window: 16-word shift line with one expansion adder.
// Depends on shabc_pkg.
module shabc_sched (
  input  logic                  clk,
  input  shabc_pkg::sched_ctrl_t ctrl,
  input  shabc_pkg::word_t      word_in,
  output shabc_pkg::word_t      w_cur
);
  import shabc_pkg::*;

  word_t win [BLOCK_WORDS];
  word_t w_new;

  // W[t+16] from the window that holds W[t] at its head
  assign w_new = small_sigma1(win[BLOCK_WORDS-2]) + win[BLOCK_WORDS-7]
               + small_sigma0(win[1]) + win[0];
  assign w_cur = win[0];

  // Shift in message words, or shift in expanded words during the rounds
  always_ff @(posedge clk) begin
    if (ctrl.shift_in || ctrl.step) begin
      for (int i = 0; i < BLOCK_WORDS-1; i++) begin
        win[i] <= win[i+1];
      end
      win[BLOCK_WORDS-1] <= ctrl.shift_in ? word_in : w_new;
    end
  end

endmodule

// ----- sv/shabc_round.sv -----
// Shared SHA-256 round unit: working variables a..h and one round per step.
// Depends on shabc_pkg.
module shabc_round (
  input  logic                   clk,
  input  shabc_pkg::round_ctrl_t ctrl,
  input  shabc_pkg::word_t       cv [shabc_pkg::HASH_WORDS],
  input  shabc_pkg::word_t       w,
  output shabc_pkg::word_t       wv [shabc_pkg::HASH_WORDS]
);
  import shabc_pkg::*;

  word_t v [HASH_WORDS];
  word_t ch;
  word_t maj;
  word_t t1;
  word_t t2;

  // Round function
  always_comb begin
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + big_sigma1(v[4]) + ch + ROUND_K[ctrl.idx] + w;
    t2  = big_sigma0(v[0]) + maj;
  end

  // Load from chaining value, then rotate the variables once per round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int j = 0; j < HASH_WORDS; j++) begin
        v[j] <= cv[j];
      end
    end else if (ctrl.step) begin
      for (int j = 1; j < HASH_WORDS; j++) begin
        if (j != 4) v[j] <= v[j-1];
      end
      v[4] <= v[3] + t1;
      v[0] <= t1 + t2;
    end
  end

  assign wv = v;

endmodule
